// ----- src/tbbss_pkg.sv -----
package tbbss_pkg;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_DRAIN,
		ST_SMOOTH,
		ST_WRITE
	} state_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ACCEPT_THRESHOLD = 2'd0,
		CFG_NEW_TARGET_LEVEL = 2'd1,
		CFG_SMOOTH_WEIGHT    = 2'd2
	} cfg_idx_t;

	// box coordinate slots
	typedef enum logic [1:0] {
		BOX_X = 2'd0,
		BOX_Y = 2'd1,
		BOX_W = 2'd2,
		BOX_H = 2'd3
	} box_idx_t;

	typedef struct packed {
		logic     capture;   // take the input word into the frame best
		logic     map_issue; // push one coordinate into the mapping pipe
		box_idx_t map_idx;
		logic     smooth;    // register the low-pass sums
		logic     write;     // commit held state and load the output word
	} cmd_t;

	typedef struct packed {
		logic map_done;   // last coordinate leaves the mapping pipe
		logic slot_free;  // output register can take a word this cycle
	} status_t;

	localparam logic [15:0] ACCEPT_THRESHOLD_RST = 16'd0;
	localparam logic [15:0] NEW_TARGET_LEVEL_RST = 16'd62259;
	localparam logic [8:0]  SMOOTH_WEIGHT_RST    = 9'd218;
	localparam logic [8:0]  WEIGHT_ONE           = 9'd256;

	// floor(2^26 / 50): quotient estimate is exact or one low
	localparam logic [20:0] DIV50_RECIP = 21'd1342177;
	localparam int          DIV50_SHIFT = 26;
	localparam logic [5:0]  FIFTY       = 6'd50;

	localparam logic signed [24:0] BOX_MAX_W = 25'sd8191;
	localparam logic signed [24:0] BOX_MIN_W = -25'sd8192;

	function automatic logic signed [13:0] sat14(input logic signed [24:0] v);
		logic signed [13:0] r;
		if (v > BOX_MAX_W) begin
			r = 14'sd8191;
		end else if (v < BOX_MIN_W) begin
			r = -14'sd8192;
		end else begin
			r = v[13:0];
		end
		return r;
	endfunction

	// division by two, truncated toward zero
	function automatic logic signed [13:0] half14(input logic signed [13:0] v);
		logic signed [14:0] t;
		t = {v[13], v} + {14'd0, v[13]};
		return t[14:1];
	endfunction

endpackage

// ----- src/tracker_best_box_select_smooth_core.sv -----
// Best-box selector and size smoother for a patch-scoring tracker. Each input
// word is one scored patch; the block keeps the first strict maximum of the
// frame and, on the last patch, emits one output word: found with the tracked
// box in frame pixels, or a loss (all zero, hit count cleared) when the best
// score is under accept_threshold or the word is flagged empty_frame. A patch
// that is not last is only captured. A last patch runs through capture, four
// coordinates issued into a shared three-stage mapping pipe (signed multiply,
// multiply by the reciprocal of 50, remainder correction), a drain, the size
// low-pass products and the commit. An empty-frame word goes from capture
// straight to the commit. The commit cycle waits while the output register still
// holds an untaken word; new input words are not taken until the commit.
module tracker_best_box_select_smooth_core (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	// input word
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [15:0]         score,
	input  logic signed [7:0]   net_x,
	input  logic signed [7:0]   net_y,
	input  logic signed [7:0]   net_w,
	input  logic signed [7:0]   net_h,
	input  logic [11:0]         crop_x,
	input  logic [11:0]         crop_y,
	input  logic [12:0]         crop_w,
	input  logic [12:0]         crop_h,
	input  logic                last_patch,
	input  logic                empty_frame,
	// output word
	output logic                out_valid,
	input  logic                out_stall,
	output logic                found,
	output logic [15:0]         best_score,
	output logic signed [13:0]  box_x,
	output logic signed [13:0]  box_y,
	output logic signed [13:0]  box_w,
	output logic signed [13:0]  box_h,
	output logic [7:0]          hit_count
);

	tbbss_pkg::cmd_t    cmd;
	tbbss_pkg::status_t status;

	// sequencer: capture, mapping issue, drain, smooth, commit
	tbbss_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_patch  (last_patch),
		.empty_frame (empty_frame),
		.status      (status),
		.in_stall    (in_stall),
		.cmd         (cmd)
	);

	// frame best, mapping pipe, smoothing and output register
	tbbss_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.score       (score),
		.net_x       (net_x),
		.net_y       (net_y),
		.net_w       (net_w),
		.net_h       (net_h),
		.crop_x      (crop_x),
		.crop_y      (crop_y),
		.crop_w      (crop_w),
		.crop_h      (crop_h),
		.last_patch  (last_patch),
		.empty_frame (empty_frame),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.best_score  (best_score),
		.box_x       (box_x),
		.box_y       (box_y),
		.box_w       (box_w),
		.box_h       (box_h),
		.hit_count   (hit_count)
	);

endmodule

// ----- src/tbbss_ctrl.sv -----
module tbbss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                last_patch,
	input  logic                empty_frame,
	input  tbbss_pkg::status_t  status,
	output logic                in_stall,
	output tbbss_pkg::cmd_t     cmd
);

	tbbss_pkg::state_t state_q, state_d;
	logic [1:0]        cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbbss_pkg::ST_IDLE;
			cnt_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		in_stall      = 1'b1;
		cmd           = '0;
		cmd.map_idx   = tbbss_pkg::box_idx_t'(cnt_q);
		unique case (state_q)
			tbbss_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					cnt_d       = 2'd0;
					if (empty_frame) begin
						state_d = tbbss_pkg::ST_WRITE;
					end else if (last_patch) begin
						state_d = tbbss_pkg::ST_MAP;
					end
				end
			end
			tbbss_pkg::ST_MAP: begin
				cmd.map_issue = 1'b1;
				cnt_d         = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					state_d = tbbss_pkg::ST_DRAIN;
				end
			end
			tbbss_pkg::ST_DRAIN: begin
				if (status.map_done) begin
					state_d = tbbss_pkg::ST_SMOOTH;
				end
			end
			tbbss_pkg::ST_SMOOTH: begin
				cmd.smooth = 1'b1;
				state_d    = tbbss_pkg::ST_WRITE;
			end
			tbbss_pkg::ST_WRITE: begin
				if (status.slot_free) begin
					cmd.write = 1'b1;
					state_d   = tbbss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tbbss_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/tbbss_dp.sv -----
module tbbss_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tbbss_pkg::cmd_t     cmd,
	output tbbss_pkg::status_t  status,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [15:0]         score,
	input  logic signed [7:0]   net_x,
	input  logic signed [7:0]   net_y,
	input  logic signed [7:0]   net_w,
	input  logic signed [7:0]   net_h,
	input  logic [11:0]         crop_x,
	input  logic [11:0]         crop_y,
	input  logic [12:0]         crop_w,
	input  logic [12:0]         crop_h,
	input  logic                last_patch,
	input  logic                empty_frame,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                found,
	output logic [15:0]         best_score,
	output logic signed [13:0]  box_x,
	output logic signed [13:0]  box_y,
	output logic signed [13:0]  box_w,
	output logic signed [13:0]  box_h,
	output logic [7:0]          hit_count
);

	// configuration
	logic [15:0] thresh_q, level_q;
	logic [8:0]  weight_q;

	// frame best
	logic               mid_frame_q, empty_q;
	logic [15:0]        top_score_q;
	logic signed [7:0]  top_net_q [4];
	logic [12:0]        top_crop_q [4];

	// tracked target
	logic               target_held_q;
	logic [7:0]         held_count_q;
	logic signed [13:0] held_q [4];

	// mapping pipe
	logic               vld_s1, vld_s2;
	logic [1:0]         idx_s1, idx_s2;
	logic signed [22:0] n_s1;
	logic [21:0]        mag_s2;
	logic               neg_s2;
	logic [16:0]        q0_s2;
	logic signed [13:0] cur_q [4];

	// smoothing sums
	logic signed [24:0] sum_w_q, sum_h_q;

	logic out_valid_q;
	logic take_best;

	assign take_best = !mid_frame_q || (score > top_score_q);

	assign status.slot_free = !out_valid_q || !out_stall;
	assign status.map_done  = vld_s2 && (idx_s2 == 2'(tbbss_pkg::BOX_H));
	assign out_valid        = out_valid_q;

	// ---- stage 1: numerator = 50*pos + net*size
	logic [11:0]        s1_pos;
	logic [12:0]        s1_size;
	logic signed [7:0]  s1_net;
	logic [17:0]        s1_pos50;
	logic signed [22:0] s1_prod;

	always_comb begin
		s1_net   = top_net_q[cmd.map_idx];
		s1_size  = top_crop_q[{1'b1, cmd.map_idx[0]}];
		s1_pos   = cmd.map_idx[1] ? 12'd0 : top_crop_q[{1'b0, cmd.map_idx[0]}][11:0];
		s1_pos50 = 18'(s1_pos * tbbss_pkg::FIFTY);
		s1_prod  = $signed({{15{s1_net[7]}}, s1_net}) * $signed({10'd0, s1_size});
	end

	// ---- stage 2: magnitude times reciprocal of 50
	logic [21:0] s2_mag;
	logic [42:0] s2_prod;

	always_comb begin
		s2_mag  = n_s1[22] ? 22'(-n_s1) : n_s1[21:0];
		s2_prod = {21'd0, s2_mag} * {22'd0, tbbss_pkg::DIV50_RECIP};
	end

	// ---- stage 3: one-step correction, sign, saturate
	logic [22:0]        s3_rem;
	logic [16:0]        s3_q;
	logic signed [24:0] s3_val;

	always_comb begin
		s3_rem = {1'b0, mag_s2} - 23'(q0_s2 * tbbss_pkg::FIFTY);
		s3_q   = (s3_rem >= 23'(tbbss_pkg::FIFTY)) ? q0_s2 + 17'd1 : q0_s2;
		s3_val = neg_s2 ? -$signed({8'd0, s3_q}) : $signed({8'd0, s3_q});
	end

	// ---- smoothing sums
	logic [8:0]         sm_k, sm_kc;
	logic signed [24:0] sm_w, sm_h;

	always_comb begin
		sm_k  = (weight_q > tbbss_pkg::WEIGHT_ONE) ? tbbss_pkg::WEIGHT_ONE : weight_q;
		sm_kc = tbbss_pkg::WEIGHT_ONE - sm_k;
		sm_w  = $signed({{11{held_q[2][13]}}, held_q[2]}) * $signed({16'd0, sm_k})
		      + $signed({{11{cur_q[2][13]}}, cur_q[2]}) * $signed({16'd0, sm_kc});
		sm_h  = $signed({{11{held_q[3][13]}}, held_q[3]}) * $signed({16'd0, sm_k})
		      + $signed({{11{cur_q[3][13]}}, cur_q[3]}) * $signed({16'd0, sm_kc});
	end

	// ---- final: size filter, center keep, decision
	logic signed [24:0] fin_w_full, fin_h_full, fin_cx, fin_cy;
	logic signed [13:0] fin_nw, fin_nh, fin_bx, fin_by;
	logic               fin_lose, fin_new;

	always_comb begin
		fin_w_full = (sum_w_q + (sum_w_q[24] ? 25'sd255 : 25'sd0)) >>> 8;
		fin_h_full = (sum_h_q + (sum_h_q[24] ? 25'sd255 : 25'sd0)) >>> 8;
		fin_nw     = tbbss_pkg::sat14(fin_w_full);
		fin_nh     = tbbss_pkg::sat14(fin_h_full);
		fin_cx     = 25'(cur_q[0]) + 25'(tbbss_pkg::half14(cur_q[2]));
		fin_cy     = 25'(cur_q[1]) + 25'(tbbss_pkg::half14(cur_q[3]));
		fin_bx     = tbbss_pkg::sat14(fin_cx - 25'(tbbss_pkg::half14(fin_nw)));
		fin_by     = tbbss_pkg::sat14(fin_cy - 25'(tbbss_pkg::half14(fin_nh)));
		fin_lose   = empty_q || (top_score_q < thresh_q);
		fin_new    = !target_held_q || (top_score_q > level_q);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q      <= tbbss_pkg::ACCEPT_THRESHOLD_RST;
			level_q       <= tbbss_pkg::NEW_TARGET_LEVEL_RST;
			weight_q      <= tbbss_pkg::SMOOTH_WEIGHT_RST;
			mid_frame_q   <= 1'b0;
			empty_q       <= 1'b0;
			top_score_q   <= 16'd0;
			target_held_q <= 1'b0;
			held_count_q  <= 8'd0;
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					2'(tbbss_pkg::CFG_ACCEPT_THRESHOLD): thresh_q <= cfg_data;
					2'(tbbss_pkg::CFG_NEW_TARGET_LEVEL): level_q  <= cfg_data;
					2'(tbbss_pkg::CFG_SMOOTH_WEIGHT):    weight_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (cmd.capture) begin
				empty_q <= empty_frame;
				if (empty_frame) begin
					mid_frame_q <= 1'b0;
				end else begin
					mid_frame_q <= !last_patch;
					if (take_best) begin
						top_score_q <= score;
					end
				end
			end
			vld_s1 <= cmd.map_issue;
			vld_s2 <= vld_s1;
			if (cmd.write) begin
				if (fin_lose) begin
					target_held_q <= 1'b0;
					held_count_q  <= 8'd0;
				end else if (fin_new) begin
					target_held_q <= 1'b1;
					if (held_count_q != 8'hFF) begin
						held_count_q <= held_count_q + 8'd1;
					end
				end
			end
			out_valid_q <= cmd.write || (out_valid_q && out_stall);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture && !empty_frame && take_best) begin
			top_net_q[0]  <= net_x;
			top_net_q[1]  <= net_y;
			top_net_q[2]  <= net_w;
			top_net_q[3]  <= net_h;
			top_crop_q[0] <= {1'b0, crop_x};
			top_crop_q[1] <= {1'b0, crop_y};
			top_crop_q[2] <= crop_w;
			top_crop_q[3] <= crop_h;
		end
		if (cmd.map_issue) begin
			n_s1   <= $signed({5'd0, s1_pos50}) + s1_prod;
			idx_s1 <= cmd.map_idx;
		end
		if (vld_s1) begin
			mag_s2 <= s2_mag;
			neg_s2 <= n_s1[22];
			q0_s2  <= s2_prod[tbbss_pkg::DIV50_SHIFT +: 17];
			idx_s2 <= idx_s1;
		end
		if (vld_s2) begin
			cur_q[idx_s2] <= tbbss_pkg::sat14(s3_val);
		end
		if (cmd.smooth) begin
			sum_w_q <= sm_w;
			sum_h_q <= sm_h;
		end
		if (cmd.write) begin
			if (fin_lose) begin
				found      <= 1'b0;
				best_score <= 16'd0;
				box_x      <= 14'sd0;
				box_y      <= 14'sd0;
				box_w      <= 14'sd0;
				box_h      <= 14'sd0;
				hit_count  <= 8'd0;
			end else begin
				found      <= 1'b1;
				best_score <= top_score_q;
				if (fin_new) begin
					held_q[0] <= cur_q[0];
					held_q[1] <= cur_q[1];
					held_q[2] <= cur_q[2];
					held_q[3] <= cur_q[3];
					box_x     <= cur_q[0];
					box_y     <= cur_q[1];
					box_w     <= cur_q[2];
					box_h     <= cur_q[3];
					hit_count <= (held_count_q == 8'hFF) ? held_count_q
					                                    : held_count_q + 8'd1;
				end else begin
					held_q[0] <= fin_bx;
					held_q[1] <= fin_by;
					held_q[2] <= fin_nw;
					held_q[3] <= fin_nh;
					box_x     <= fin_bx;
					box_y     <= fin_by;
					box_w     <= fin_nw;
					box_h     <= fin_nh;
					hit_count <= held_count_q;
				end
			end
		end
	end

endmodule
